/* hdl/mie_pkg.sv */
// Shared types and constants for the modular inverse block.
// Used by every module under hdl; depends on nothing else.
`timescale 1ns / 1ps

package mie_pkg;

  // Default word width; the working width is one bit less.
  localparam int DATA_WIDTH_DEF = 64;

  // Fixed widths of the stream fields.
  localparam int FIELD_W     = 63;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 128;

  // One finished result as it leaves the core.
  typedef struct packed {
    logic [FIELD_W-1:0] inverse;
    logic [FIELD_W-1:0] divisor;
    logic               has_inverse;
  } mie_res_t;

  // Status the core reports to the stream wrapper.
  typedef struct packed {
    logic idle;
    logic res_valid;
  } mie_stat_t;

endpackage

/* hdl/mie_step_unit.sv */
// Shared arithmetic unit: one restoring division bit plus the matching
// shift-add of the Bezout coefficient product. Uses mie_pkg.
`timescale 1ns / 1ps

module mie_step_unit
  import mie_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic [DATA_WIDTH-2:0] rem,
  input  logic                  din,
  input  logic [DATA_WIDTH-2:0] divisor,
  input  logic [DATA_WIDTH-1:0] acc,
  input  logic [DATA_WIDTH-1:0] coef,
  output logic [DATA_WIDTH-2:0] rem_nxt,
  output logic [DATA_WIDTH-1:0] acc_nxt
);

  localparam int W  = DATA_WIDTH - 1;
  localparam int DW = DATA_WIDTH;

  logic [W:0]    rem_sh;
  logic [W:0]    rem_sub;
  logic          qbit;
  logic [DW-1:0] acc_sh;

  // Bring in the next dividend bit and try the subtraction.
  always_comb begin
    rem_sh  = {rem, din};
    rem_sub = rem_sh - {1'b0, divisor};
    qbit    = (rem_sh >= {1'b0, divisor});
    rem_nxt = qbit ? rem_sub[W-1:0] : rem_sh[W-1:0];
  end

  // Quotient times coefficient, built MSB first, wrapping at the word width.
  always_comb begin
    acc_sh  = {acc[DW-2:0], 1'b0};
    acc_nxt = qbit ? (acc_sh + coef) : acc_sh;
  end

endmodule

/* hdl/mie_core.sv */
// Sequencer and registers of the extended Euclidean algorithm.
// Instantiates mie_step_unit; uses mie_pkg.
`timescale 1ns / 1ps

module mie_core
  import mie_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DATA_WIDTH-2:0] value,
  input  logic [DATA_WIDTH-2:0] modulus,
  input  logic                  res_ready,
  output mie_stat_t             stat,
  output mie_res_t              res
);

  localparam int W  = DATA_WIDTH - 1;
  localparam int DW = DATA_WIDTH;
  localparam int CW = $clog2(DATA_WIDTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_ABS  = 3'd4;
  localparam logic [2:0] S_RED  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [W-1:0]  r0_r, r0_nxt;
  logic [W-1:0]  r1_r, r1_nxt;
  logic [W-1:0]  m_r, m_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  shf_r, shf_nxt;
  logic [DW-1:0] s0_r, s0_nxt;
  logic [DW-1:0] s1_r, s1_nxt;
  logic [DW-1:0] t_r, t_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt;
  mie_res_t      res_r, res_nxt;

  logic [W-1:0]  unit_rem;
  logic [DW-1:0] unit_acc;
  logic [W-1:0]  inv_w;

  // Shared division and coefficient unit.
  mie_step_unit #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_step (
    .rem     (rem_r),
    .din     (shf_r[W-1]),
    .divisor (r1_r),
    .acc     (t_r),
    .coef    (s1_r),
    .rem_nxt (unit_rem),
    .acc_nxt (unit_acc)
  );

  // Final coefficient mapped into zero to modulus minus one.
  always_comb begin
    if (m_r == '0) begin
      inv_w = '0;
    end else if (neg_r) begin
      inv_w = (t_r == '0) ? '0 : (m_r - t_r[W-1:0]);
    end else begin
      inv_w = t_r[W-1:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    r0_nxt    = r0_r;
    r1_nxt    = r1_r;
    m_nxt     = m_r;
    rem_nxt   = rem_r;
    shf_nxt   = shf_r;
    s0_nxt    = s0_r;
    s1_nxt    = s1_r;
    t_nxt     = t_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    res_nxt   = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          r0_nxt    = value;
          r1_nxt    = modulus;
          m_nxt     = modulus;
          s0_nxt    = DW'(1);
          s1_nxt    = '0;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (r1_r == '0) begin
          state_nxt = S_ABS;
        end else begin
          rem_nxt   = '0;
          t_nxt     = '0;
          shf_nxt   = r0_r;
          cnt_nxt   = CW'(W - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = unit_rem;
        t_nxt   = unit_acc;
        shf_nxt = {shf_r[W-2:0], 1'b0};
        if (cnt_r == '0) begin
          state_nxt = S_UPD;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      S_UPD: begin
        r0_nxt    = r1_r;
        r1_nxt    = rem_r;
        s0_nxt    = s1_r;
        s1_nxt    = s0_r - t_r;
        state_nxt = S_CHK;
      end
      S_ABS: begin
        neg_nxt   = s0_r[DW-1];
        t_nxt     = s0_r[DW-1] ? ({DW{1'b0}} - s0_r) : s0_r;
        state_nxt = S_RED;
      end
      S_RED: begin
        if (m_r != '0 && t_r >= {1'b0, m_r}) begin
          t_nxt = t_r - {1'b0, m_r};
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        res_nxt.inverse     = FIELD_W'(inv_w);
        res_nxt.divisor     = FIELD_W'(r0_r);
        res_nxt.has_inverse = (r0_r == W'(1));
        state_nxt           = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state is reset; the datapath is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r0_r  <= r0_nxt;
    r1_r  <= r1_nxt;
    m_r   <= m_nxt;
    rem_r <= rem_nxt;
    shf_r <= shf_nxt;
    s0_r  <= s0_nxt;
    s1_r  <= s1_nxt;
    t_r   <= t_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign stat.idle      = (state_r == S_IDLE);
  assign stat.res_valid = (state_r == S_DONE);
  assign res            = res_r;

  // A division never runs against a zero divisor.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (r1_r != '0))
    else $error("division step with zero divisor");

  // The partial remainder always stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < r1_r))
    else $error("partial remainder not below divisor");

  // After the single correction the magnitude is below the modulus.
  a_red_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && m_r != '0) |-> (t_r < {1'b0, m_r}))
    else $error("coefficient not reduced below modulus");

  // A finished result stays offered until it is taken.
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.res_valid && !res_ready) |=> (stat.res_valid && $stable(res)))
    else $error("result dropped before it was taken");

endmodule

/* hdl/modular_inverse_euclid_top.sv */
// Channel   | Dir | Handshake               | Payload
// in_       | in  | in_tvalid / in_tready   | in_tdata: value
// out_      | out | out_tvalid / out_tready | out_tdata: inverse, divisor; out_tuser: has_inverse
// cfg_      | in  | cfg_valid / cfg_ready   | cfg_data: modulus
//
// Each Euclid step is one check, a bit-serial division of the remainder through the
// shared step unit, and one update.
// in_tready is high only while the core is idle; a stalled result waits in the
// output register, and the core is free again once the result is moved there.
// Reset (rst_n, synchronous, active low) sets the modulus to 1 and empties the block.
// Depends on mie_pkg and mie_core.
`timescale 1ns / 1ps

module modular_inverse_euclid_top
  import mie_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [62:0] value
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [62:0] inverse, [125:63] divisor
  output logic                   out_tuser,  // [0] has_inverse
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [FIELD_W-1:0]     cfg_data    // modulus
);

  localparam int W = DATA_WIDTH - 1;

  logic [FIELD_W-1:0] mod_r, mod_nxt;
  logic               out_valid_r, out_valid_nxt;
  mie_res_t           out_res_r, out_res_nxt;
  mie_stat_t          stat;
  mie_res_t           res;
  logic               res_ready;
  logic               start;

  // Modulus register; the core copies it when a request starts, so a write
  // never disturbs a request in flight.
  assign cfg_ready = 1'b1;
  assign mod_nxt   = (cfg_valid && cfg_ready) ? cfg_data : mod_r;

  // Input request starts the core when it is idle.
  assign in_tready = stat.idle;
  assign start     = in_tvalid && in_tready;

  mie_core #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .value     (in_tdata[W-1:0]),
    .modulus   (mod_r[W-1:0]),
    .res_ready (res_ready),
    .stat      (stat),
    .res       (res)
  );

  // Output register between the core and the result channel.
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (stat.res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r       <= FIELD_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      mod_r       <= mod_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 2 * FIELD_W){1'b0}},
                       out_res_r.divisor, out_res_r.inverse};
  assign out_tuser  = out_res_r.has_inverse;

endmodule
